>>> rtl/sha_pkg.sv
// ============================================================================
// sha_pkg
// Shared types, round constants and bit functions for the SHA-256 hasher.
// ============================================================================
package sha_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic push;       // append one byte to the block
        logic word_done;  // this byte completes a 32-bit word
        logic shift;      // advance the window by one round
    } t_sched_ctl;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic init;     // load working variables from the chain
        logic step;     // run one round
        logic fold;     // add working variables into the chain
        logic restore;  // reload the initial chain values
    } t_round_ctl;

    localparam int unsigned NumWords   = 8;
    localparam int unsigned WinDepth   = 16;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenStart   = 56;

    localparam logic        KindData   = 1'b0;
    localparam logic        KindFinish = 1'b1;
    localparam logic [7:0]  PadByte    = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] iv_const(input logic [2:0] idx);
        case (idx)
            3'd0:    iv_const = 32'h6a09e667;
            3'd1:    iv_const = 32'hbb67ae85;
            3'd2:    iv_const = 32'h3c6ef372;
            3'd3:    iv_const = 32'ha54ff53a;
            3'd4:    iv_const = 32'h510e527f;
            3'd5:    iv_const = 32'h9b05688c;
            3'd6:    iv_const = 32'h1f83d9ab;
            default: iv_const = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] k_const(input logic [5:0] idx);
        case (idx)
            6'd0:  k_const = 32'h428a2f98;  6'd1:  k_const = 32'h71374491;
            6'd2:  k_const = 32'hb5c0fbcf;  6'd3:  k_const = 32'he9b5dba5;
            6'd4:  k_const = 32'h3956c25b;  6'd5:  k_const = 32'h59f111f1;
            6'd6:  k_const = 32'h923f82a4;  6'd7:  k_const = 32'hab1c5ed5;
            6'd8:  k_const = 32'hd807aa98;  6'd9:  k_const = 32'h12835b01;
            6'd10: k_const = 32'h243185be;  6'd11: k_const = 32'h550c7dc3;
            6'd12: k_const = 32'h72be5d74;  6'd13: k_const = 32'h80deb1fe;
            6'd14: k_const = 32'h9bdc06a7;  6'd15: k_const = 32'hc19bf174;
            6'd16: k_const = 32'he49b69c1;  6'd17: k_const = 32'hefbe4786;
            6'd18: k_const = 32'h0fc19dc6;  6'd19: k_const = 32'h240ca1cc;
            6'd20: k_const = 32'h2de92c6f;  6'd21: k_const = 32'h4a7484aa;
            6'd22: k_const = 32'h5cb0a9dc;  6'd23: k_const = 32'h76f988da;
            6'd24: k_const = 32'h983e5152;  6'd25: k_const = 32'ha831c66d;
            6'd26: k_const = 32'hb00327c8;  6'd27: k_const = 32'hbf597fc7;
            6'd28: k_const = 32'hc6e00bf3;  6'd29: k_const = 32'hd5a79147;
            6'd30: k_const = 32'h06ca6351;  6'd31: k_const = 32'h14292967;
            6'd32: k_const = 32'h27b70a85;  6'd33: k_const = 32'h2e1b2138;
            6'd34: k_const = 32'h4d2c6dfc;  6'd35: k_const = 32'h53380d13;
            6'd36: k_const = 32'h650a7354;  6'd37: k_const = 32'h766a0abb;
            6'd38: k_const = 32'h81c2c92e;  6'd39: k_const = 32'h92722c85;
            6'd40: k_const = 32'ha2bfe8a1;  6'd41: k_const = 32'ha81a664b;
            6'd42: k_const = 32'hc24b8b70;  6'd43: k_const = 32'hc76c51a3;
            6'd44: k_const = 32'hd192e819;  6'd45: k_const = 32'hd6990624;
            6'd46: k_const = 32'hf40e3585;  6'd47: k_const = 32'h106aa070;
            6'd48: k_const = 32'h19a4c116;  6'd49: k_const = 32'h1e376c08;
            6'd50: k_const = 32'h2748774c;  6'd51: k_const = 32'h34b0bcb5;
            6'd52: k_const = 32'h391c0cb3;  6'd53: k_const = 32'h4ed8aa4a;
            6'd54: k_const = 32'h5b9cca4f;  6'd55: k_const = 32'h682e6ff3;
            6'd56: k_const = 32'h748f82ee;  6'd57: k_const = 32'h78a5636f;
            6'd58: k_const = 32'h84c87814;  6'd59: k_const = 32'h8cc70208;
            6'd60: k_const = 32'h90befffa;  6'd61: k_const = 32'ha4506ceb;
            6'd62: k_const = 32'hbef9a3f7;
            default: k_const = 32'hc67178f2;
        endcase
    endfunction

endpackage

>>> rtl/sha_sched.sv
// ============================================================================
// sha_sched
// Byte packer and 16-word message schedule shift line.
// ============================================================================
module sha_sched (
    input  logic                  i_clk,
    input  sha_pkg::t_sched_ctl   i_ctl,
    input  logic [7:0]            i_byte,
    output logic [31:0]           o_w0
);

    logic [23:0] r_acc;
    logic [31:0] r_win [sha_pkg::WinDepth];
    logic [31:0] w_word;
    logic [31:0] w_new;

    assign w_word = {r_acc, i_byte};

    // W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
    assign w_new = sha_pkg::small_sigma1(r_win[14]) + r_win[9]
                 + sha_pkg::small_sigma0(r_win[1]) + r_win[0];

    assign o_w0 = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= w_word[23:0];
        end
        if ((i_ctl.push && i_ctl.word_done) || i_ctl.shift) begin
            for (int i = 0; i < sha_pkg::WinDepth - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[sha_pkg::WinDepth - 1] <= i_ctl.shift ? w_new : w_word;
        end
    end

endmodule

>>> rtl/sha_round.sv
// ============================================================================
// sha_round
// One SHA-256 round per cycle over the working variables, plus chain words.
// ============================================================================
module sha_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha_pkg::t_round_ctl   i_ctl,
    input  logic [31:0]           i_k,
    input  logic [31:0]           i_w,
    input  logic [2:0]            i_rd_idx,
    output logic [31:0]           o_word
);

    logic [31:0] r_chain [sha_pkg::NumWords];
    logic [31:0] r_v     [sha_pkg::NumWords];
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1  = r_v[7] + sha_pkg::big_sigma1(r_v[4]) + w_ch + i_k + i_w;
    assign w_t2  = sha_pkg::big_sigma0(r_v[0]) + w_maj;

    assign o_word = r_chain[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sha_pkg::NumWords; i++) begin
                r_chain[i] <= sha_pkg::iv_const(3'(i));
            end
        end else if (i_ctl.restore) begin
            for (int i = 0; i < sha_pkg::NumWords; i++) begin
                r_chain[i] <= sha_pkg::iv_const(3'(i));
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < sha_pkg::NumWords; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            for (int i = 0; i < sha_pkg::NumWords; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

endmodule

>>> rtl/sha256_message_hasher_top.sv
// ============================================================================
// sha256_message_hasher_top
// Byte-serial SHA-256: one round unit shared over 64 rounds per block.
// ============================================================================
// Data item: taken while idle; the 64th byte of a block starts 64 rounds in
//   the single round unit, then one chain fold, before the next item is taken.
// Finish item: one pad or length byte per cycle up to the block end, then the
//   rounds and fold for each block (two blocks when fewer than 9 bytes are free), then eight
//   digest words at one per cycle while the output side takes them.
// Reset (synchronous, active low): clear sequencer, fill and length, reload chain.

module sha256_message_hasher_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sha_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sha_pkg::t_out_item o_out_item
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
    localparam logic [2:0] S_PAD   = 3'd1;  // feed pad and length bytes
    localparam logic [2:0] S_ROUND = 3'd2;  // run the 64 rounds
    localparam logic [2:0] S_FOLD  = 3'd3;  // add working vars into chain
    localparam logic [2:0] S_OUT   = 3'd4;  // deliver the digest words

    localparam logic [5:0] LastFill  = 6'(sha_pkg::BlockBytes - 1);
    localparam logic [5:0] LastRound = 6'(sha_pkg::Rounds - 1);
    localparam logic [5:0] LenFill   = 6'(sha_pkg::LenStart);
    localparam logic [2:0] LastWord  = 3'(sha_pkg::NumWords - 1);

    logic [2:0]  r_state,   n_state;
    logic [5:0]  r_fill,    n_fill;      // next byte slot in the block
    logic [63:0] r_bits,    n_bits;      // message length, shifted out as bytes
    logic [5:0]  r_rc,      n_rc;        // round counter
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_first,   n_first;     // next pad byte is the 0x80 marker
    logic        r_len_ok,  n_len_ok;    // this block carries the length
    logic        r_final,   n_final;     // running compression is the last one
    logic        r_padding, n_padding;   // a finish item is in progress

    logic        w_in_fire;
    logic        w_out_fire;
    logic        w_push;
    logic        w_block_done;
    logic        w_len_slot;
    logic [7:0]  w_pad_byte;
    logic [7:0]  w_push_byte;
    logic [31:0] w_w0;
    logic [31:0] w_word;

    sha_pkg::t_sched_ctl w_sched_ctl;
    sha_pkg::t_round_ctl w_round_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = (r_state == S_OUT) && i_out_ready;

    // Pad stream: marker, zeros, then the bit length in the last eight slots
    assign w_len_slot = !r_first && r_len_ok && (r_fill >= LenFill);
    always_comb begin
        if (r_first) begin
            w_pad_byte = sha_pkg::PadByte;
        end else if (w_len_slot) begin
            w_pad_byte = r_bits[63:56];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    assign w_push = (w_in_fire && (i_in_item.kind == sha_pkg::KindData))
                  || (r_state == S_PAD);
    assign w_push_byte  = (r_state == S_PAD) ? w_pad_byte : i_in_item.byte_value;
    assign w_block_done = w_push && (r_fill == LastFill);

    assign w_sched_ctl.push      = w_push;
    assign w_sched_ctl.word_done = (r_fill[1:0] == 2'b11);
    assign w_sched_ctl.shift     = (r_state == S_ROUND);

    assign w_round_ctl.init    = w_block_done;
    assign w_round_ctl.step    = (r_state == S_ROUND);
    assign w_round_ctl.fold    = (r_state == S_FOLD);
    assign w_round_ctl.restore = w_out_fire && (r_out_idx == LastWord);

    sha_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_sched_ctl),
        .i_byte (w_push_byte),
        .o_w0   (w_w0)
    );

    sha_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_round_ctl),
        .i_k      (sha_pkg::k_const(r_rc)),
        .i_w      (w_w0),
        .i_rd_idx (r_out_idx),
        .o_word   (w_word)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_rc      = r_rc;
        n_out_idx = r_out_idx;
        n_first   = r_first;
        n_len_ok  = r_len_ok;
        n_final   = r_final;
        n_padding = r_padding;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in_item.kind == sha_pkg::KindData) begin
                        // append the byte and count its bits (wraps mod 2^64)
                        n_bits = r_bits + 64'd8;
                        n_fill = r_fill + 6'd1;
                        if (w_block_done) begin
                            n_state = S_ROUND;
                            n_rc    = '0;
                        end
                    end else begin
                        n_state   = S_PAD;
                        n_first   = 1'b1;
                        n_padding = 1'b1;
                    end
                end
            end
            S_PAD: begin
                n_fill  = r_fill + 6'd1;
                n_first = 1'b0;
                if (r_first) begin
                    // the length fits only if the marker lands before its slots
                    n_len_ok = (r_fill < LenFill);
                end
                if (w_len_slot) begin
                    n_bits = {r_bits[55:0], 8'h00};
                end
                if (w_block_done) begin
                    n_state = S_ROUND;
                    n_rc    = '0;
                    n_final = w_len_slot;
                end
            end
            S_ROUND: begin
                n_rc = r_rc + 6'd1;
                if (r_rc == LastRound) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_final) begin
                    n_state   = S_OUT;
                    n_out_idx = '0;
                end else if (r_padding) begin
                    // extra block: zeros then the length
                    n_state  = S_PAD;
                    n_len_ok = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_out_fire) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == LastWord) begin
                        // message done: drop the length and return to idle
                        n_state   = S_IDLE;
                        n_fill    = '0;
                        n_bits    = '0;
                        n_padding = 1'b0;
                        n_final   = 1'b0;
                        n_len_ok  = 1'b0;
                        n_first   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_bits    <= '0;
            r_rc      <= '0;
            r_out_idx <= '0;
            r_first   <= 1'b0;
            r_len_ok  <= 1'b0;
            r_final   <= 1'b0;
            r_padding <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_rc      <= n_rc;
            r_out_idx <= n_out_idx;
            r_first   <= n_first;
            r_len_ok  <= n_len_ok;
            r_final   <= n_final;
            r_padding <= n_padding;
        end
    end

    // Hold each digest word from registers until it is taken
    assign o_out_valid            = (r_state == S_OUT);
    assign o_out_item.digest_word = w_word;
    assign o_out_item.word_index  = r_out_idx;
    assign o_out_item.last_word   = (r_out_idx == LastWord);

endmodule

>>> rtl/sha_checker.sv
// ============================================================================
// sha_checker
// Port-level checks for the SHA-256 hasher, bound to the top level.
// ============================================================================
module sha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input sha_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sha_pkg::t_out_item o_out_item
);

    // No new item is taken while digest words are pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest words pending");

    // Valid holds until the item is taken
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before accept");

    // Stalled payload holds
    a_out_item_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    // Digest words follow back to back in index order
    a_word_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last_word |=>
            o_out_valid
            && (o_out_item.word_index == $past(o_out_item.word_index) + 3'd1))
        else $error("digest word sequence broken");

    // The last flag marks exactly the eighth word
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.last_word == (o_out_item.word_index == 3'd7)))
        else $error("last word flag mismatch");

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// SHA-256 byte-serial hasher testbench
// Streams messages of chosen lengths into the hasher one byte per item. A
// local copy of the hash algorithm predicts the eight digest words that each
// finish item produces, and each word is checked as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Nothing is accepted on either side for this many cycles: the run is hung.
    // The slowest correct gap is a two-block finish plus the one long receiver
    // hold-off (HoldCycles) plus random stalls, so the limit leaves a wide margin.
    localparam int unsigned StallLimit = 4000;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned IdlePct    = 31;
    localparam int unsigned ItemTarget = 280;
    localparam int unsigned DrainWait  = 200;

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] START_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    sha_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    sha_pkg::t_out_item o_out_item;

    sha256_message_hasher_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash predictor: its own chaining words, block buffer and bit count
    // ------------------------------------------------------------------
    logic [31:0]        chain_words [8];
    logic [7:0]         block_buf   [64];
    int unsigned        fill_cnt;
    logic [63:0]        bit_len;
    sha_pkg::t_out_item expected_words [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain_words[i] = START_HASH[i];
        fill_cnt = 0;
        bit_len  = '0;
    endtask

    // Run all 64 rounds over the buffered block and fold into the chain.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0   = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d} = {chain_words[0], chain_words[1], chain_words[2], chain_words[3]};
        {e, f, g, h} = {chain_words[4], chain_words[5], chain_words[6], chain_words[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        block_buf[fill_cnt] = value;
        bit_len  += 64'd8;
        fill_cnt  = (fill_cnt + 1) % 64;
        if (fill_cnt == 0) compress_block();
    endtask

    // Pad, append the bit length, compress, and queue the eight digest words.
    task automatic close_message();
        int unsigned        idx;
        sha_pkg::t_out_item word;
        idx = fill_cnt;
        block_buf[idx] = 8'h80;
        idx++;
        if (idx > 56) begin
            // no room for the length: spill into an extra block
            while (idx < 64) begin
                block_buf[idx] = 8'h00;
                idx++;
            end
            compress_block();
            idx = 0;
        end
        while (idx < 56) begin
            block_buf[idx] = 8'h00;
            idx++;
        end
        for (int i = 0; i < 8; i++) block_buf[56 + i] = bit_len[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            word.digest_word = chain_words[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            expected_words.push_back(word);
        end
        restart_hash();
    endtask

    // ------------------------------------------------------------------
    // Stimulus store and counters shared by the processes below
    // ------------------------------------------------------------------
    sha_pkg::t_in_item pending_items [$];
    logic              in_taken      = 1'b0;
    int unsigned       sent_count    = 0;
    int unsigned       words_checked = 0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       hold_left     = 0;
    logic              hold_done     = 1'b0;
    int unsigned       fail_count    = 0;

    task automatic queue_item(input logic kind, input logic [7:0] value);
        sha_pkg::t_in_item item;
        item.kind       = kind;
        item.byte_value = value;
        pending_items.push_back(item);
    endtask

    task automatic queue_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) queue_item(sha_pkg::KindData, 8'($urandom));
        queue_item(sha_pkg::KindFinish, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Input driver: change at the falling edge, advance on acceptance
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic idle;
        if (i_rst_n) begin
            // keep the input busy during the long hold-off so the block backs up
            idle = (hold_left == 0) && !(sent_count >= 150 && sent_count < 210)
                && ($urandom_range(0, 99) < IdlePct);
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() > 0 && !idle) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_items.pop_front();
                    sent_count <= sent_count + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random stalls, one calm window, one long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && words_checked >= 16) begin
                hold_done   <= 1'b1;
                hold_left   <= HoldCycles;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (words_checked >= 64 && words_checked < 128)
                            || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input item, check each digest word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sha_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                if (i_in_item.kind == sha_pkg::KindData) absorb_byte(i_in_item.byte_value);
                else close_message();
            end
            if (o_out_valid && i_out_ready) begin
                words_checked <= words_checked + 1;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected digest word expected none actual %h",
                             $time, o_out_item);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_out_item.digest_word !== want.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, want.digest_word, o_out_item.digest_word);
                        fail_count++;
                    end
                    if (o_out_item.word_index !== want.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want.word_index, o_out_item.word_index);
                        fail_count++;
                    end
                    if (o_out_item.last_word !== want.last_word) begin
                        $display("%0t: last_word expected %b actual %b",
                                 $time, want.last_word, o_out_item.last_word);
                        fail_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: end the run if traffic stops for too long.
    initial begin
        while (quiet_cycles < StallLimit) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, release reset, wait for drain, report
    // ------------------------------------------------------------------
    initial begin
        restart_hash();

        // Directed: empty message with a nonzero byte on the finish item
        // (must be ignored), then an empty message with a zero byte.
        queue_item(sha_pkg::KindFinish, 8'hff);
        queue_item(sha_pkg::KindFinish, 8'h00);
        // "abc"
        queue_item(sha_pkg::KindData, 8'h61);
        queue_item(sha_pkg::KindData, 8'h62);
        queue_item(sha_pkg::KindData, 8'h63);
        queue_item(sha_pkg::KindFinish, 8'ha5);
        // byte extremes and the pad value itself as data
        queue_item(sha_pkg::KindData, 8'h00);
        queue_item(sha_pkg::KindData, 8'hff);
        queue_item(sha_pkg::KindData, 8'h80);
        queue_item(sha_pkg::KindData, 8'h7f);
        queue_item(sha_pkg::KindFinish, 8'h5a);
        queue_item(sha_pkg::KindData, 8'h55);
        queue_item(sha_pkg::KindFinish, 8'haa);

        // Random messages, weighted toward short ones and toward lengths
        // around the pad-spill and block boundaries.
        while (pending_items.size() < ItemTarget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_message($urandom_range(0, 12));
                4, 5:       queue_message($urandom_range(52, 60));
                6:          queue_message($urandom_range(62, 66));
                7:          queue_message($urandom_range(118, 122));
                default:    queue_message($urandom_range(0, 3));
            endcase
        end

        // hold reset, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        // let any stray output show up before the verdict
        repeat (DrainWait) @(posedge i_clk);

        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
